// ===== hdl/midi_track_event_parser_top_defines.svh =====
// ----------------------------------------------------------------------------
// MIDI track event parser assertion macros
// Shared concurrent assertion forms for the parser RTL.
// ----------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_PARSER_TOP_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MTEP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define MTEP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mtep_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Phase codes, result kinds, error codes and the result record.
// ----------------------------------------------------------------------------
package mtep_pkg;

  parameter int MAX_VLQ_BYTES = 4;
  localparam logic [2:0] VLQ_LIMIT = 3'(MAX_VLQ_BYTES);

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_DATA1,
    PH_DATA2,
    PH_METATYPE,
    PH_LEN,
    PH_PAYLOAD
  } phase_t;

  localparam logic [1:0] KIND_CHANNEL = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  localparam logic [3:0] ERR_NONE          = 4'd0;
  localparam logic [3:0] ERR_BAD_DELTA     = 4'd1;
  localparam logic [3:0] ERR_NO_STATUS     = 4'd2;
  localparam logic [3:0] ERR_BAD_STATUS    = 4'd3;
  localparam logic [3:0] ERR_BAD_DATA      = 4'd4;
  localparam logic [3:0] ERR_CHANNEL_SHORT = 4'd5;
  localparam logic [3:0] ERR_HEADER_SHORT  = 4'd6;
  localparam logic [3:0] ERR_BAD_LENGTH    = 4'd7;
  localparam logic [3:0] ERR_PAYLOAD_SHORT = 4'd8;

  localparam logic [7:0] ST_SYSEX      = 8'hF0;
  localparam logic [7:0] ST_SYSEX_CONT = 8'hF7;
  localparam logic [7:0] ST_META       = 8'hFF;
  localparam logic [3:0] HI_PROG       = 4'hC;
  localparam logic [3:0] HI_PRESSURE   = 4'hD;
  localparam logic [3:0] HI_SYSTEM     = 4'hF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [27:0] delta_ticks;
    logic [7:0]  status_value;
    logic [6:0]  first_param;
    logic [6:0]  second_param;
    logic [7:0]  meta_kind;
    logic [27:0] payload_length;
    logic [7:0]  payload_value;
    logic [3:0]  error_code;
    logic [28:0] event_bytes;
    logic        last;
  } result_t;

endpackage

// ===== hdl/midi_track_event_parser_top.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser
// Parses Standard MIDI File track events from a byte stream, one byte a beat.
// ----------------------------------------------------------------------------
// Takes one track byte per clock cycle while track_stall is low and returns at
// most one result per byte. The parser state is updated in the same cycle the
// byte is taken, so bytes can stream with no gaps. Results are registered in
// an output register backed by a one-entry skid register that takes a result
// when the consumer stalls; track_stall is high only while the skid register
// holds a result, i.e. after the consumer has stalled with both entries full.
`include "midi_track_event_parser_top_defines.svh"

module midi_track_event_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        track_valid,
  output logic        track_stall,
  input  logic [7:0]  track_byte,
  input  logic        buffer_end,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [27:0] delta_ticks,
  output logic [7:0]  status_value,
  output logic [6:0]  first_param,
  output logic [6:0]  second_param,
  output logic [7:0]  meta_kind,
  output logic [27:0] payload_length,
  output logic [7:0]  payload_value,
  output logic [3:0]  error_code,
  output logic [28:0] event_bytes,
  output logic        last
);

  mtep_pkg::phase_t phase, phase_next;
  logic [7:0]  chan_status, chan_status_next;
  logic [27:0] vlq_accum, vlq_accum_next;
  logic [2:0]  vlq_count, vlq_count_next;
  logic [27:0] held_delta, held_delta_next;
  logic [7:0]  held_status, held_status_next;
  logic [6:0]  held_first, held_first_next;
  logic [7:0]  held_meta_kind, held_meta_kind_next;
  logic [27:0] bytes_left, bytes_left_next;
  logic [28:0] byte_count, byte_count_next;

  mtep_pkg::result_t res, out_reg, skid_reg;
  logic        res_valid;
  logic        skid_valid;
  logic        accept;
  logic        out_fire;

  logic [27:0] acc_push;
  logic [2:0]  cnt_push;
  logic        use_first;
  logic        do_fail;
  logic [3:0]  fail_code;
  logic        do_begin;
  logic [28:0] total;

  assign accept      = track_valid && !track_stall;
  assign out_fire    = result_valid && !result_stall;
  assign track_stall = skid_valid;

  assign acc_push = {vlq_accum[20:0], track_byte[6:0]};
  assign cnt_push = vlq_count + 3'd1;
  assign total    = byte_count + 29'd1 + {1'b0, acc_push};

  always_comb begin
    phase_next          = phase;
    chan_status_next    = chan_status;
    vlq_accum_next      = vlq_accum;
    vlq_count_next      = vlq_count;
    held_delta_next     = held_delta;
    held_status_next    = held_status;
    held_first_next     = held_first;
    held_meta_kind_next = held_meta_kind;
    bytes_left_next     = bytes_left;
    byte_count_next     = byte_count + 29'd1;
    res                 = '0;
    res_valid           = 1'b0;
    use_first           = 1'b0;
    do_fail             = 1'b0;
    fail_code           = mtep_pkg::ERR_NONE;
    do_begin            = 1'b0;

    case (phase)
      mtep_pkg::PH_DELTA: begin
        vlq_accum_next = acc_push;
        vlq_count_next = cnt_push;
        if (track_byte[7]) begin
          if (cnt_push >= mtep_pkg::VLQ_LIMIT || buffer_end) begin
            do_fail   = 1'b1;
            fail_code = mtep_pkg::ERR_BAD_DELTA;
          end
        end else begin
          held_delta_next = acc_push;
          vlq_accum_next  = '0;
          vlq_count_next  = '0;
          phase_next      = mtep_pkg::PH_STATUS;
          if (buffer_end) begin
            do_fail   = 1'b1;
            fail_code = mtep_pkg::ERR_NO_STATUS;
          end
        end
      end
      mtep_pkg::PH_STATUS: begin
        if (track_byte[7:4] == mtep_pkg::HI_SYSTEM) begin
          held_status_next = track_byte;
          if (track_byte == mtep_pkg::ST_META) begin
            chan_status_next = '0;
            phase_next       = mtep_pkg::PH_METATYPE;
            if (buffer_end) begin
              do_fail   = 1'b1;
              fail_code = mtep_pkg::ERR_HEADER_SHORT;
            end
          end else if (track_byte == mtep_pkg::ST_SYSEX ||
                       track_byte == mtep_pkg::ST_SYSEX_CONT) begin
            chan_status_next = '0;
            vlq_accum_next   = '0;
            vlq_count_next   = '0;
            phase_next       = mtep_pkg::PH_LEN;
            if (buffer_end) begin
              do_fail   = 1'b1;
              fail_code = mtep_pkg::ERR_HEADER_SHORT;
            end
          end else begin
            do_fail   = 1'b1;
            fail_code = mtep_pkg::ERR_BAD_STATUS;
          end
        end else if (track_byte[7]) begin
          held_status_next = track_byte;
          chan_status_next = track_byte;
          phase_next       = mtep_pkg::PH_DATA1;
          if (buffer_end) begin
            do_fail   = 1'b1;
            fail_code = mtep_pkg::ERR_CHANNEL_SHORT;
          end
        end else if (chan_status[7] &&
                     chan_status[7:4] != mtep_pkg::HI_SYSTEM) begin
          held_status_next = chan_status;
          use_first        = 1'b1;
        end else begin
          do_fail   = 1'b1;
          fail_code = mtep_pkg::ERR_NO_STATUS;
        end
      end
      mtep_pkg::PH_DATA1: begin
        use_first = 1'b1;
      end
      mtep_pkg::PH_DATA2: begin
        if (track_byte[7]) begin
          do_fail   = 1'b1;
          fail_code = mtep_pkg::ERR_BAD_DATA;
        end else begin
          res.kind         = mtep_pkg::KIND_CHANNEL;
          res.first_param  = held_first;
          res.second_param = track_byte[6:0];
          res.event_bytes  = byte_count_next;
          res.last         = 1'b1;
          res_valid        = 1'b1;
          do_begin         = 1'b1;
        end
      end
      mtep_pkg::PH_METATYPE: begin
        held_meta_kind_next = track_byte;
        vlq_accum_next      = '0;
        vlq_count_next      = '0;
        phase_next          = mtep_pkg::PH_LEN;
        if (buffer_end) begin
          do_fail   = 1'b1;
          fail_code = mtep_pkg::ERR_HEADER_SHORT;
        end
      end
      mtep_pkg::PH_LEN: begin
        vlq_accum_next = acc_push;
        vlq_count_next = cnt_push;
        if (track_byte[7]) begin
          if (cnt_push >= mtep_pkg::VLQ_LIMIT || buffer_end) begin
            do_fail   = 1'b1;
            fail_code = mtep_pkg::ERR_BAD_LENGTH;
          end
        end else if (acc_push == '0) begin
          res.kind        = mtep_pkg::KIND_HEADER;
          res.meta_kind   = held_meta_kind;
          res.event_bytes = total;
          res.last        = 1'b1;
          res_valid       = 1'b1;
          do_begin        = 1'b1;
        end else if (buffer_end) begin
          do_fail   = 1'b1;
          fail_code = mtep_pkg::ERR_PAYLOAD_SHORT;
        end else begin
          bytes_left_next    = acc_push;
          phase_next         = mtep_pkg::PH_PAYLOAD;
          res.kind           = mtep_pkg::KIND_HEADER;
          res.meta_kind      = held_meta_kind;
          res.payload_length = acc_push;
          res.event_bytes    = total;
          res_valid          = 1'b1;
        end
      end
      mtep_pkg::PH_PAYLOAD: begin
        bytes_left_next = bytes_left - 28'd1;
        if (bytes_left_next != '0 && buffer_end) begin
          do_fail   = 1'b1;
          fail_code = mtep_pkg::ERR_PAYLOAD_SHORT;
        end else begin
          res.kind           = mtep_pkg::KIND_PAYLOAD;
          res.meta_kind      = held_meta_kind;
          res.payload_length = vlq_accum;
          res.payload_value  = track_byte;
          res.event_bytes    = byte_count_next;
          res.last           = (bytes_left_next == '0);
          res_valid          = 1'b1;
          do_begin           = (bytes_left_next == '0);
        end
      end
      default: begin
        do_begin = 1'b1;
      end
    endcase

    // first channel data byte, direct or under running status
    if (use_first) begin
      if (track_byte[7]) begin
        do_fail   = 1'b1;
        fail_code = mtep_pkg::ERR_BAD_DATA;
      end else if (held_status_next[7:4] != mtep_pkg::HI_PROG &&
                   held_status_next[7:4] != mtep_pkg::HI_PRESSURE) begin
        held_first_next = track_byte[6:0];
        phase_next      = mtep_pkg::PH_DATA2;
        if (buffer_end) begin
          do_fail   = 1'b1;
          fail_code = mtep_pkg::ERR_CHANNEL_SHORT;
        end
      end else begin
        res.kind        = mtep_pkg::KIND_CHANNEL;
        res.first_param = track_byte[6:0];
        res.event_bytes = byte_count_next;
        res.last        = 1'b1;
        res_valid       = 1'b1;
        do_begin        = 1'b1;
      end
    end

    if (do_fail) begin
      res            = '0;
      res.kind       = mtep_pkg::KIND_ERROR;
      res.error_code = fail_code;
      res.event_bytes = byte_count_next;
      res.last       = 1'b1;
      res_valid      = 1'b1;
      do_begin       = 1'b1;
    end

    res.delta_ticks  = held_delta_next;
    res.status_value = held_status_next;

    if (do_begin) begin
      phase_next          = mtep_pkg::PH_DELTA;
      vlq_accum_next      = '0;
      vlq_count_next      = '0;
      held_delta_next     = '0;
      held_status_next    = '0;
      held_first_next     = '0;
      held_meta_kind_next = '0;
      bytes_left_next     = '0;
      byte_count_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= mtep_pkg::PH_DELTA;
      chan_status    <= '0;
      vlq_accum      <= '0;
      vlq_count      <= '0;
      held_delta     <= '0;
      held_status    <= '0;
      held_first     <= '0;
      held_meta_kind <= '0;
      bytes_left     <= '0;
      byte_count     <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      chan_status    <= chan_status_next;
      vlq_accum      <= vlq_accum_next;
      vlq_count      <= vlq_count_next;
      held_delta     <= held_delta_next;
      held_status    <= held_status_next;
      held_first     <= held_first_next;
      held_meta_kind <= held_meta_kind_next;
      bytes_left     <= bytes_left_next;
      byte_count     <= byte_count_next;
    end
  end

  // output register with one-entry skid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (accept && res_valid) begin
      if (result_valid && !out_fire) begin
        skid_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end else if (out_fire) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_reg <= skid_reg;
      end
    end else if (accept && res_valid) begin
      if (result_valid && !out_fire) begin
        skid_reg <= res;
      end else begin
        out_reg <= res;
      end
    end
  end

  assign kind           = out_reg.kind;
  assign delta_ticks    = out_reg.delta_ticks;
  assign status_value   = out_reg.status_value;
  assign first_param    = out_reg.first_param;
  assign second_param   = out_reg.second_param;
  assign meta_kind      = out_reg.meta_kind;
  assign payload_length = out_reg.payload_length;
  assign payload_value  = out_reg.payload_value;
  assign error_code     = out_reg.error_code;
  assign event_bytes    = out_reg.event_bytes;
  assign last           = out_reg.last;

  `MTEP_ASSERT_NOW(a_skid_behind_out, skid_valid, result_valid, "skid full with output empty")
  `MTEP_ASSERT_NEXT(a_last_restarts, accept && res_valid && res.last, phase == mtep_pkg::PH_DELTA, "event end did not restart delta")
  `MTEP_ASSERT_NOW(a_delta_clean, phase == mtep_pkg::PH_DELTA, held_status == '0 && bytes_left == '0, "stale event state in delta phase")
  `MTEP_ASSERT_NOW(a_error_is_last, result_valid && kind == mtep_pkg::KIND_ERROR, last && error_code != mtep_pkg::ERR_NONE, "error result malformed")

endmodule
